FILE: hdl/button_debounce_long_press_defines.svh
// Assertion macros used by the port checker of the button debouncer.
// No dependencies; include by bare file name.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDLP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset too.
`define BDLP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bdlp_pkg.sv
// Package of the button debouncer: constants, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int BTN_COUNT   = 3;
    localparam int TICK_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET   = 16'd100;
    localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Register indexes of the configuration channel.
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_EN    = 2'd2;

    // Effective tick counts (zero already mapped to one).
    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
    } tick_cfg_t;

    // Per-button result of one tick.
    typedef struct packed {
        logic stable;
        logic changed;
        logic long_press;
    } btn_evt_t;

endpackage

FILE: hdl/bdlp_cfg.sv
// Configuration register file of the button debouncer.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_cfg #(
    parameter int NUM_BUTTONS = bdlp_pkg::BTN_COUNT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output bdlp_pkg::tick_cfg_t                tick_cfg,
    output logic [NUM_BUTTONS-1:0]             long_press_en
);
    import bdlp_pkg::*;

    logic [TICK_W-1:0]      debounce_reg;
    logic [TICK_W-1:0]      long_press_reg;
    logic [NUM_BUTTONS-1:0] enable_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            enable_reg     <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_data[TICK_W-1:0];
                REG_LONG_PRESS_TICKS: long_press_reg <= cfg_data[TICK_W-1:0];
                REG_LONG_PRESS_EN:    enable_reg     <= cfg_data[NUM_BUTTONS-1:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    // A programmed zero behaves as one tick.
    assign tick_cfg.debounce_ticks   = (debounce_reg == '0) ? TICK_W'(1) : debounce_reg;
    assign tick_cfg.long_press_ticks = (long_press_reg == '0) ? TICK_W'(1) : long_press_reg;
    assign long_press_en             = enable_reg;

endmodule

FILE: hdl/bdlp_cell.sv
// One button lane: debounce countdown, debounced level and long-press countdown.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                primed,
    input  logic                raw,
    input  logic                long_press_en,
    input  bdlp_pkg::tick_cfg_t tick_cfg,
    output bdlp_pkg::btn_evt_t  evt
);
    import bdlp_pkg::*;

    logic              prev_raw_reg, prev_raw_next;
    logic              stable_reg, stable_next;
    logic [TICK_W-1:0] deb_cnt_reg, deb_cnt_next;
    logic [TICK_W-1:0] long_cnt_reg, long_cnt_next;
    logic              changed;
    logic              long_hit;

    always_comb begin
        prev_raw_next = raw;
        stable_next   = stable_reg;
        deb_cnt_next  = deb_cnt_reg;
        long_cnt_next = long_cnt_reg;
        changed       = 1'b0;
        long_hit      = 1'b0;
        if (!primed) begin
            stable_next = raw;
        end else begin
            // long-press countdown advances first
            if (long_cnt_reg != '0) begin
                long_cnt_next = long_cnt_reg - TICK_W'(1);
                long_hit      = (long_cnt_reg == TICK_W'(1));
            end
            if (raw != prev_raw_reg) begin
                deb_cnt_next = tick_cfg.debounce_ticks;
            end else if (deb_cnt_reg != '0) begin
                deb_cnt_next = deb_cnt_reg - TICK_W'(1);
                if (deb_cnt_reg == TICK_W'(1) && raw != stable_reg) begin
                    if (raw) begin
                        if (long_press_en) begin
                            long_cnt_next = tick_cfg.long_press_ticks;
                        end
                    end else begin
                        long_cnt_next = '0;
                    end
                    stable_next = raw;
                    changed     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg <= 1'b0;
            stable_reg   <= 1'b0;
            deb_cnt_reg  <= '0;
            long_cnt_reg <= '0;
        end else if (step) begin
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            deb_cnt_reg  <= deb_cnt_next;
            long_cnt_reg <= long_cnt_next;
        end
    end

    assign evt.stable     = stable_next;
    assign evt.changed    = changed;
    assign evt.long_press = long_hit;

endmodule

FILE: hdl/button_debounce_long_press.sv
// Top level of the button debouncer with long-press detection.
// Depends on bdlp_pkg, bdlp_cfg and bdlp_cell.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake             Payload
//  s_        in   s_tvalid / s_tready   s_tdata: raw_levels
//  m_        out  m_tvalid / m_tready   m_tdata: stable_out, changed_mask, long_press_mask
//  cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
//  Cycles: one tick beat per clock while s_tready is high (see Stalls); its result beat
//  is valid the cycle after it is taken, held in the result register.
//  Reset (aresetn low, synchronous) loads 100 / 1000 ticks, all long presses enabled,
//  idle counters and clears the result valid flag; the first tick only loads the levels.
//  Stalls: s_tready drops only while a result beat waits and m_tready is low.
//  cfg_ready is always high; write only while no tick beat is in flight.

module button_debounce_long_press #(
    parameter int NUM_BUTTONS = bdlp_pkg::BTN_COUNT,
    localparam int S_W = ((NUM_BUTTONS + 7) / 8) * 8,
    localparam int M_W = ((3 * NUM_BUTTONS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tick input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_W-1:0]                   s_tdata,   // raw_levels
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_W-1:0]                   m_tdata,   // stable_out, changed_mask,
                                                        // long_press_mask
    // register writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bdlp_pkg::*;

    tick_cfg_t              tick_cfg;
    logic [NUM_BUTTONS-1:0] long_press_en;
    logic                   step;
    logic                   primed_reg;
    btn_evt_t               evt [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] stable_vec, changed_vec, long_vec;
    logic                   m_tvalid_reg;
    logic [M_W-1:0]         m_tdata_reg;

    bdlp_cfg #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tick_cfg      (tick_cfg),
        .long_press_en (long_press_en)
    );

    // Take a new tick whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        bdlp_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .step          (step),
            .primed        (primed_reg),
            .raw           (s_tdata[i]),
            .long_press_en (long_press_en[i]),
            .tick_cfg      (tick_cfg),
            .evt           (evt[i])
        );
        assign stable_vec[i]  = evt[i].stable;
        assign changed_vec[i] = evt[i].changed;
        assign long_vec[i]    = evt[i].long_press;
    end

    // The first tick after reset primes the levels.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (step) begin
            primed_reg <= 1'b1;
        end
    end

    // Result register: hold while stalled, load on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= M_W'({long_vec, changed_vec, stable_vec});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/bdlp_checker.sv
// Port-level checker of the button debouncer, bound to the top level.
// Depends on bdlp_pkg and button_debounce_long_press_defines.svh.
`timescale 1ns / 1ps
`include "button_debounce_long_press_defines.svh"

module bdlp_port_checker #(
    parameter int NUM_BUTTONS = bdlp_pkg::BTN_COUNT,
    localparam int M_W = ((3 * NUM_BUTTONS + 7) / 8) * 8
) (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [M_W-1:0] m_tdata
);
    import bdlp_pkg::*;

    logic                   seen_reg;
    logic [NUM_BUTTONS-1:0] last_stable_reg;
    logic [NUM_BUTTONS-1:0] stable_f, changed_f;
    logic                   out_beat;
    logic                   in_beat;

    assign stable_f  = m_tdata[NUM_BUTTONS-1:0];
    assign changed_f = m_tdata[2*NUM_BUTTONS-1:NUM_BUTTONS];
    assign out_beat  = m_tvalid && m_tready;
    assign in_beat   = s_tvalid && s_tready;

    // Track the debounced levels of the last delivered beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (out_beat) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_beat) begin
            last_stable_reg <= stable_f;
        end
    end

    `BDLP_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_tvalid,
        "result beat valid right after reset")

    `BDLP_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready,
        "tick input stalled with an empty result register")

    `BDLP_ASSERT_NEXT(a_result_follows_tick, aclk, aresetn, in_beat, m_tvalid,
        "accepted tick produced no result beat")

    `BDLP_ASSERT_SAME(a_level_tracks_change, aclk, aresetn, out_beat && seen_reg,
        stable_f == (last_stable_reg ^ changed_f),
        "debounced level moved without a change flag")

    `BDLP_ASSERT_NEXT(a_hold_when_stalled, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result beat dropped or changed")

endmodule

bind button_debounce_long_press bdlp_port_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
